FILE: hw/rtl/dtv_pkg.sv
// Shared types and constants for the dual TSDF voxel table.
package dtv_pkg;

  localparam int NUM_VOXELS  = 4096;
  localparam int WEIGHT_BITS = 16;
  localparam int VOX_AW      = $clog2(NUM_VOXELS);
  localparam int DIST_W      = 16;
  localparam int TRUNC_W     = 15;
  localparam int ENT_W       = DIST_W + WEIGHT_BITS;
  localparam int PROD_W      = DIST_W + WEIGHT_BITS + 1;
  localparam int NUM_W       = PROD_W - 1;
  localparam int DIV_W       = WEIGHT_BITS + 1;
  localparam int QUO_W       = DIST_W;
  localparam logic [TRUNC_W-1:0] TRUNC_RESET = 15'd1229;

  typedef enum logic [1:0] {
    REQ_UPDATE   = 2'd0,
    REQ_QUERY    = 2'd1,
    REQ_CLR_CUR  = 2'd2,
    REQ_CLR_STAT = 2'd3
  } req_t;

  typedef struct packed {
    req_t               req_type;
    logic [11:0]        voxel_index;
    logic signed [15:0] observed_distance;
    logic               to_static;
  } in_data_t;

  typedef struct packed {
    logic [15:0]        distance_difference;
    logic signed [15:0] static_distance;
    logic signed [15:0] current_distance;
    logic               static_seen;
    logic               current_seen;
  } out_data_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    req_t                     req;
    logic                     idx_ok;
    logic [VOX_AW-1:0]        addr;
    logic signed [DIST_W-1:0] x;
    logic                     to_static;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLEAR,
    B_LOAD,
    B_MUL,
    B_DIV
  } back_state_t;

endpackage

FILE: hw/rtl/dtv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/dtv_front.sv
// Front end: accepts transactions, clamps the distance and queues commands.
module dtv_front import dtv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_data_t           in_data,
  input  logic [TRUNC_W-1:0] trunc,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output cmd_t               cmd
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       c_in;
  logic signed [DIST_W:0] x_ext, t_pos, t_neg;
  logic       push;

  always_comb begin
    x_ext = {in_data.observed_distance[DIST_W-1], in_data.observed_distance};
    t_pos = (DIST_W+1)'({1'b0, trunc});
    t_neg = -t_pos;
    c_in.req       = in_data.req_type;
    c_in.idx_ok    = 32'(in_data.voxel_index) < NUM_VOXELS;
    c_in.addr      = VOX_AW'(in_data.voxel_index);
    c_in.to_static = in_data.to_static;
    if (x_ext > t_pos) begin
      c_in.x = t_pos[DIST_W-1:0];
    end else if (x_ext < t_neg) begin
      c_in.x = t_neg[DIST_W-1:0];
    end else begin
      c_in.x = in_data.observed_distance;
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= c_in;
    end
  end

endmodule

FILE: hw/rtl/dtv_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module dtv_div import dtv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  localparam int CW = $clog2(QUO_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt, d_r;
  logic [QUO_W-1:0] sh_r, sh_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DIV_W:0]   trial;

  // Quotient fits QUO_W bits, so the dividend's upper part is already below the divisor.
  always_comb begin
    trial    = {rem_r, sh_r[QUO_W-1]} - {1'b0, d_r};
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done     = busy_r && (cnt_r == '0);
    if (start) begin
      rem_nxt  = DIV_W'(dividend[NUM_W-1:QUO_W]);
      sh_nxt   = dividend[QUO_W-1:0];
      cnt_nxt  = CW'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (!trial[DIV_W]) begin
          rem_nxt = trial[DIV_W-1:0];
          sh_nxt  = {sh_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DIV_W-2:0], sh_r[QUO_W-1]};
          sh_nxt  = {sh_r[QUO_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign quotient = sh_r;

endmodule

FILE: hw/rtl/dtv_back.sv
// Back end: voxel store, clear sweeps, weighted-average fold and query results.
module dtv_back import dtv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  cmd_t               cmd,
  input  logic [TRUNC_W-1:0] trunc,
  output logic               out_valid,
  input  logic               out_ready,
  output out_data_t          out_data
);

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [1:0]  mask_r, mask_nxt;       // [1] static half, [0] current half
  logic [VOX_AW-1:0] clr_r, clr_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_data_t   out_r, out_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, num;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt, w_inc;
  logic        neg_r, neg_nxt;

  logic             st_we, cu_we, re;
  logic [VOX_AW-1:0] waddr;
  logic [ENT_W-1:0] wdata, st_rd, cu_rd;
  logic signed [DIST_W-1:0] st_avg, cu_avg, sel_avg, new_avg, t16, s_val, c_val;
  logic [WEIGHT_BITS-1:0] st_w, cu_w, sel_w;
  logic        s_seen, c_seen;
  logic signed [DIST_W:0] diff;
  logic        div_start, div_done;
  logic [NUM_W-1:0] mag;
  logic [DIV_W-1:0] dsor;
  logic [QUO_W-1:0] quo;
  logic        clr_last;

  dtv_ram #(.WIDTH(ENT_W), .DEPTH(NUM_VOXELS)) u_st_ram (
    .clk(clk), .we(st_we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(cmd.addr), .rdata(st_rd)
  );

  dtv_ram #(.WIDTH(ENT_W), .DEPTH(NUM_VOXELS)) u_cu_ram (
    .clk(clk), .we(cu_we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(cmd.addr), .rdata(cu_rd)
  );

  dtv_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mag),
    .divisor(dsor), .done(div_done), .quotient(quo)
  );

  assign st_avg   = st_rd[ENT_W-1:WEIGHT_BITS];
  assign st_w     = st_rd[WEIGHT_BITS-1:0];
  assign cu_avg   = cu_rd[ENT_W-1:WEIGHT_BITS];
  assign cu_w     = cu_rd[WEIGHT_BITS-1:0];
  assign sel_avg  = cmd_r.to_static ? st_avg : cu_avg;
  assign sel_w    = cmd_r.to_static ? st_w : cu_w;
  assign t16      = DIST_W'({1'b0, trunc});
  assign clr_last = (clr_r == VOX_AW'(NUM_VOXELS - 1));
  assign new_avg  = neg_r ? -quo : quo;
  assign w_inc    = (w_r == '1) ? w_r : w_r + 1'b1;

  always_comb begin
    num  = prod_r + PROD_W'(cmd_r.x);
    mag  = num[PROD_W-1] ? NUM_W'(-num) : num[NUM_W-1:0];
    dsor = {1'b0, w_r} + 1'b1;
  end

  always_comb begin
    s_seen = cmd_r.idx_ok && (st_w != '0);
    c_seen = cmd_r.idx_ok && (cu_w != '0);
    s_val  = s_seen ? st_avg : t16;
    c_val  = c_seen ? cu_avg : t16;
    if (!s_seen) begin
      diff = '0;
    end else begin
      diff = {c_val[DIST_W-1], c_val} - {s_val[DIST_W-1], s_val};
    end
    if (diff[DIST_W]) begin
      diff = -diff;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    mask_nxt      = mask_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    prod_nxt      = prod_r;
    w_nxt         = w_r;
    neg_nxt       = neg_r;
    cmd_pop       = 1'b0;
    re            = 1'b0;
    div_start     = 1'b0;
    st_we         = 1'b0;
    cu_we         = 1'b0;
    waddr         = cmd_r.addr;
    wdata         = {new_avg, w_inc};
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          case (cmd.req)
            REQ_CLR_CUR: begin
              mask_nxt  = 2'b01;
              clr_nxt   = '0;
              state_nxt = B_CLEAR;
            end
            REQ_CLR_STAT: begin
              mask_nxt  = 2'b10;
              clr_nxt   = '0;
              state_nxt = B_CLEAR;
            end
            REQ_QUERY: begin
              re        = 1'b1;
              state_nxt = B_LOAD;
            end
            default: begin
              // update outside the table is dropped
              if (cmd.idx_ok) begin
                re        = 1'b1;
                state_nxt = B_LOAD;
              end
            end
          endcase
        end
      end
      B_CLEAR: begin
        waddr = clr_r;
        wdata = '0;
        st_we = mask_r[1];
        cu_we = mask_r[0];
        clr_nxt = clr_r + 1'b1;
        if (clr_last) begin
          state_nxt = B_IDLE;
        end
      end
      B_LOAD: begin
        if (cmd_r.req == REQ_QUERY) begin
          if (!out_valid_r || out_ready) begin
            out_valid_nxt               = 1'b1;
            out_nxt.distance_difference = diff[DIST_W-1:0];
            out_nxt.static_distance     = s_val;
            out_nxt.current_distance    = c_val;
            out_nxt.static_seen         = s_seen;
            out_nxt.current_seen        = c_seen;
            state_nxt                   = B_IDLE;
          end
        end else begin
          prod_nxt  = sel_avg * $signed({1'b0, sel_w});
          w_nxt     = sel_w;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        neg_nxt   = num[PROD_W-1];
        div_start = 1'b1;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        if (div_done) begin
          st_we     = cmd_r.to_static;
          cu_we     = !cmd_r.to_static;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      mask_r      <= 2'b11;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r  <= cmd_nxt;
    out_r  <= out_nxt;
    prod_r <= prod_nxt;
    w_r    <= w_nxt;
    neg_r  <= neg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_dual_write_only_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_we && cu_we) |-> (state_r == B_CLEAR))
    else $error("both halves written outside a clear sweep");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == B_DIV))
    else $error("divider finished outside the divide state");

  a_sweep_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CLEAR && !clr_last) |=> (state_r == B_CLEAR))
    else $error("clear sweep left early");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == B_IDLE && cmd_valid))
    else $error("command taken while busy");

endmodule

FILE: hw/rtl/dual_tsdf_voxel_table.sv
// Top level of the dual TSDF voxel table.
// Update, accept to write-back: pop, read, multiply, divide; query: pop, read, registered result.
// Update throughput is set by the back end's shared divider; a clear pops and then sweeps the store.
// A two-entry command queue keeps input acceptance going meanwhile, until both entries are full.
// Reset (rst_n, synchronous): truncation distance goes to 1229 and a sweep over all 4096 voxels
// zeroes both halves of the store before the first command is executed.
module dual_tsdf_voxel_table import dtv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_data_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_data_t          out_data,
  input  logic               cfg_we,
  input  logic [TRUNC_W-1:0] cfg_wdata
);

  logic [TRUNC_W-1:0] trunc_r, trunc_nxt;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  assign trunc_nxt = cfg_we ? cfg_wdata : trunc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunc_r <= TRUNC_RESET;
    end else begin
      trunc_r <= trunc_nxt;
    end
  end

  dtv_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .trunc(trunc_r), .cmd_valid(cmd_valid),
    .cmd_pop(cmd_pop), .cmd(cmd)
  );

  dtv_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
    .cmd(cmd), .trunc(trunc_r), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );

endmodule
